// File: design/mapool_pkg.sv
`default_nettype none
package mapool_pkg;

   localparam int CHAN_W = 10;
   localparam int FP_W = 32;
   localparam int ROWS = 9;
   localparam int CSR_ADDR_W = 2;

   localparam logic [FP_W-1:0] CANON_NAN = 32'h7FC0_0000;
   localparam logic [FP_W-1:0] SCALE_RESET = 32'h3F80_0000;
   localparam logic [FP_W-1:0] CLAMP_LOW_RESET = 32'hFF80_0000;
   localparam logic [FP_W-1:0] CLAMP_HIGH_RESET = 32'h7F80_0000;

   localparam logic [CSR_ADDR_W-1:0] CSR_SCALE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CLAMP_LOW = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CLAMP_HIGH = 2'd2;

   typedef struct packed {
      logic [FP_W-1:0] scale;
      logic [FP_W-1:0] clamp_low;
      logic [FP_W-1:0] clamp_high;
   } cfg_type;

   typedef struct packed {
      logic [CHAN_W-1:0] channel;
      logic [FP_W-1:0] sum;
   } sum_item_type;

   typedef struct packed {
      logic special;
      logic [FP_W-1:0] sval;
      logic sign;
      logic signed [10:0] exp;
      logic [47:0] prod;
   } mul_pre_type;

   function automatic logic [5:0] lzc48(input logic [47:0] x);
      logic [5:0] lz;
      lz = 6'd48;
      for (int i = 0; i < 48; i++) begin
         if (x[i]) begin
            lz = 6'(47 - i);
         end
      end
      return lz;
   endfunction

   function automatic logic [FP_W-1:0] fp_add(input logic [FP_W-1:0] a,
                                              input logic [FP_W-1:0] b);
      logic a_nan, b_nan, a_inf, b_inf, swap, sl, ss, lost, rnd, zero;
      logic [31:0] big, sml, res;
      logic [7:0] el, es, d;
      logic [23:0] ml, ms;
      logic [26:0] xl, xs, xsh;
      logic [27:0] s;
      logic [5:0] lz;
      logic [9:0] e, sh;
      logic [24:0] m;
      a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      swap = a[30:0] < b[30:0];
      big = swap ? b : a;
      sml = swap ? a : b;
      sl = big[31];
      ss = sml[31];
      el = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      ml = {big[30:23] != 8'd0, big[22:0]};
      ms = {sml[30:23] != 8'd0, sml[22:0]};
      d = el - es;
      xl = {ml, 3'b000};
      xs = {ms, 3'b000};
      if (d >= 8'd27) begin
         xsh = '0;
         lost = (xs != '0);
      end else begin
         xsh = xs >> d;
         lost = ((xsh << d) != xs);
      end
      xsh[0] = xsh[0] | lost;
      if (sl == ss) begin
         s = {1'b0, xl} + {1'b0, xsh};
      end else begin
         s = {1'b0, xl} - {1'b0, xsh};
      end
      zero = (s == 28'd0);
      e = {2'b00, el};
      lz = 6'd0;
      sh = 10'd0;
      if (s[27]) begin
         s = {1'b0, s[27:2], s[1] | s[0]};
         e = e + 10'd1;
      end else if (!zero) begin
         lz = lzc48({s[26:0], 21'd0});
         sh = ({4'd0, lz} < (e - 10'd1)) ? {4'd0, lz} : (e - 10'd1);
         s = s << sh;
         e = e - sh;
      end
      rnd = s[2] & (s[1] | s[0] | s[3]);
      m = {1'b0, s[26:3]} + {24'd0, rnd};
      if (m[24]) begin
         m = {1'b0, m[24:1]};
         e = e + 10'd1;
      end
      if (a_nan || b_nan) begin
         res = CANON_NAN;
      end else if (a_inf && b_inf) begin
         res = (a[31] != b[31]) ? CANON_NAN : a;
      end else if (a_inf) begin
         res = a;
      end else if (b_inf) begin
         res = b;
      end else if (zero) begin
         res = {sl & ss, 31'd0};
      end else if (e >= 10'd255) begin
         res = {sl, 8'hFF, 23'd0};
      end else begin
         res = {sl, m[23] ? e[7:0] : 8'd0, m[22:0]};
      end
      return res;
   endfunction

   function automatic mul_pre_type fp_mul_pre(input logic [FP_W-1:0] a,
                                              input logic [FP_W-1:0] b);
      mul_pre_type p;
      logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sg;
      logic [7:0] ea, eb;
      logic [23:0] ma, mb;
      a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      a_zero = (a[30:0] == 31'd0);
      b_zero = (b[30:0] == 31'd0);
      sg = a[31] ^ b[31];
      ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      ma = {a[30:23] != 8'd0, a[22:0]};
      mb = {b[30:23] != 8'd0, b[22:0]};
      p.sign = sg;
      p.prod = 48'(ma) * 48'(mb);
      p.exp = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126;
      p.special = 1'b1;
      if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
         p.sval = CANON_NAN;
      end else if (a_inf || b_inf) begin
         p.sval = {sg, 8'hFF, 23'd0};
      end else if (a_zero || b_zero) begin
         p.sval = {sg, 31'd0};
      end else begin
         p.sval = '0;
         p.special = 1'b0;
      end
      return p;
   endfunction

   function automatic logic [FP_W-1:0] fp_mul_fin(input mul_pre_type p);
      logic [5:0] lz;
      logic [47:0] q, q2;
      logic signed [11:0] e;
      logic [11:0] sh;
      logic lost, st, rnd;
      logic [24:0] m;
      logic [31:0] res;
      lz = lzc48(p.prod);
      q = p.prod << lz;
      e = $signed({p.exp[10], p.exp}) - $signed({6'd0, lz});
      lost = 1'b0;
      if (e < 12'sd1) begin
         sh = 12'(12'sd1 - e);
         if (sh >= 12'd48) begin
            lost = (q != 48'd0);
            q = '0;
         end else begin
            q2 = q >> sh;
            lost = ((q2 << sh) != q);
            q = q2;
         end
         e = 12'sd1;
      end
      st = (|q[22:0]) | lost;
      rnd = q[23] & (st | q[24]);
      m = {1'b0, q[47:24]} + {24'd0, rnd};
      if (m[24]) begin
         m = {1'b0, m[24:1]};
         e = e + 12'sd1;
      end
      if (p.special) begin
         res = p.sval;
      end else if (e >= 12'sd255) begin
         res = {p.sign, 8'hFF, 23'd0};
      end else begin
         res = {p.sign, m[23] ? e[7:0] : 8'd0, m[22:0]};
      end
      return res;
   endfunction

   function automatic logic fp_lt(input logic [FP_W-1:0] a, input logic [FP_W-1:0] b);
      logic a_nan, b_nan, r;
      a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      if (a_nan || b_nan) begin
         r = 1'b0;
      end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
         r = 1'b0;
      end else if (a[31] != b[31]) begin
         r = a[31];
      end else if (!a[31]) begin
         r = a[30:0] < b[30:0];
      end else begin
         r = a[30:0] > b[30:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: design/mapool_sum.sv
`default_nettype none
module mapool_sum import mapool_pkg::*; #(
   parameter int MAX_CHANNELS = 1024
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic in_ready,
   input  wire logic [CHAN_W-1:0] in_channel,
   input  wire logic [ROWS-1:0][FP_W-1:0] in_rows,
   input  wire logic in_first,
   input  wire logic in_last,
   output logic out_valid,
   input  wire logic out_ready,
   output sum_item_type out_item
);

   localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int RED_W = 27;
   localparam longint RECIP = ((64'sd1 <<< 32) + longint'(MAX_CHANNELS) - 64'sd1)
                              / longint'(MAX_CHANNELS);

   function automatic logic [IDX_W-1:0] chan_index(input logic [CHAN_W-1:0] ch);
      logic [CHAN_W+32:0] prod;
      logic [CHAN_W-1:0] q;
      logic [RED_W-1:0] r;
      prod = (CHAN_W+33)'(ch) * (CHAN_W+33)'(RECIP);
      q = prod[CHAN_W+31:32];
      r = RED_W'(ch) - RED_W'(q) * RED_W'(MAX_CHANNELS);
      return IDX_W'(r);
   endfunction

   logic [FP_W-1:0] mem [MAX_CHANNELS];
   logic [FP_W-1:0] rd_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic last1_ff, last2_ff, last3_ff, last4_ff;
   logic first1_ff;
   logic [CHAN_W-1:0] ch1_ff, ch2_ff, ch3_ff, ch4_ff;
   logic [IDX_W-1:0] idx1_ff, idx2_ff, idx3_ff, idx4_ff;
   logic [ROWS-1:0][FP_W-1:0] rows1_ff;
   logic [FP_W-1:0] s01_ff, s23_ff, s45_ff, s67_ff, slot_ff;
   logic [FP_W-1:0] s01a_ff, s2345_ff, s67b_ff;
   logic [FP_W-1:0] s0167a_ff, s2345b_ff;

   logic rdy1, rdy2, rdy3, rdy4, accept, match, wr_en;
   logic [IDX_W-1:0] idx_in;
   logic [FP_W-1:0] slot, sum4;

   assign idx_in = chan_index(in_channel);
   assign match = (v1_ff && !last1_ff && (idx1_ff == idx_in))
               || (v2_ff && !last2_ff && (idx2_ff == idx_in))
               || (v3_ff && !last3_ff && (idx3_ff == idx_in))
               || (v4_ff && !last4_ff && (idx4_ff == idx_in));

   assign rdy4 = !v4_ff || !last4_ff || out_ready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign in_ready = rdy1 && !(!in_first && match);
   assign accept = in_valid && in_ready;

   assign slot = first1_ff ? rows1_ff[8] : rd_ff;
   assign sum4 = fp_add(s2345b_ff, s0167a_ff);
   assign wr_en = v4_ff && !last4_ff;

   assign out_valid = v4_ff && last4_ff;
   assign out_item = '{channel: ch4_ff, sum: sum4};

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= mem[idx_in];
      end
      if (wr_en) begin
         mem[idx4_ff] <= sum4;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= accept;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (rdy4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         last1_ff <= in_last;
         first1_ff <= in_first;
         ch1_ff <= in_channel;
         idx1_ff <= idx_in;
         rows1_ff <= in_rows;
      end
      if (rdy2) begin
         last2_ff <= last1_ff;
         ch2_ff <= ch1_ff;
         idx2_ff <= idx1_ff;
         s01_ff <= fp_add(rows1_ff[0], rows1_ff[1]);
         s23_ff <= fp_add(rows1_ff[2], rows1_ff[3]);
         s45_ff <= fp_add(rows1_ff[4], rows1_ff[5]);
         s67_ff <= fp_add(rows1_ff[6], rows1_ff[7]);
         slot_ff <= slot;
      end
      if (rdy3) begin
         last3_ff <= last2_ff;
         ch3_ff <= ch2_ff;
         idx3_ff <= idx2_ff;
         s01a_ff <= fp_add(s01_ff, slot_ff);
         s2345_ff <= fp_add(s23_ff, s45_ff);
         s67b_ff <= s67_ff;
      end
      if (rdy4) begin
         last4_ff <= last3_ff;
         ch4_ff <= ch3_ff;
         idx4_ff <= idx3_ff;
         s0167a_ff <= fp_add(s01a_ff, s67b_ff);
         s2345b_ff <= s2345_ff;
      end
   end

endmodule
`default_nettype wire

// File: design/mapool_scale.sv
`default_nettype none
module mapool_scale import mapool_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic in_ready,
   input  wire sum_item_type in_item,
   input  wire cfg_type cfg,
   output logic out_valid,
   input  wire logic out_ready,
   output logic [FP_W-1:0] out_average,
   output logic [CHAN_W-1:0] out_channel
);

   logic va_ff, vb_ff, vc_ff, vo_ff;
   sum_item_type item_a_ff;
   mul_pre_type pre_b_ff;
   logic [CHAN_W-1:0] ch_b_ff, ch_c_ff, ch_o_ff;
   logic [FP_W-1:0] prod_c_ff, avg_o_ff;
   logic rdy_a, rdy_b, rdy_c, rdy_o;
   logic [FP_W-1:0] low_v, clamp_v;

   assign rdy_o = !vo_ff || out_ready;
   assign rdy_c = !vc_ff || rdy_o;
   assign rdy_b = !vb_ff || rdy_c;
   assign rdy_a = !va_ff || rdy_b;
   assign in_ready = rdy_a;

   assign low_v = fp_lt(prod_c_ff, cfg.clamp_low) ? cfg.clamp_low : prod_c_ff;
   assign clamp_v = fp_lt(cfg.clamp_high, low_v) ? cfg.clamp_high : low_v;

   assign out_valid = vo_ff;
   assign out_average = avg_o_ff;
   assign out_channel = ch_o_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (rdy_a) begin
            va_ff <= in_valid;
         end
         if (rdy_b) begin
            vb_ff <= va_ff;
         end
         if (rdy_c) begin
            vc_ff <= vb_ff;
         end
         if (rdy_o) begin
            vo_ff <= vc_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a) begin
         item_a_ff <= in_item;
      end
      if (rdy_b) begin
         pre_b_ff <= fp_mul_pre(item_a_ff.sum, cfg.scale);
         ch_b_ff <= item_a_ff.channel;
      end
      if (rdy_c) begin
         prod_c_ff <= fp_mul_fin(pre_b_ff);
         ch_c_ff <= ch_b_ff;
      end
      if (rdy_o) begin
         avg_o_ff <= (clamp_v[30:23] == 8'hFF && clamp_v[22:0] != 23'd0) ? CANON_NAN : clamp_v;
         ch_o_ff <= ch_c_ff;
      end
   end

endmodule
`default_nettype wire

// File: design/multipass_average_pool_f32.sv
`default_nettype none
// Multipass binary32 average pooling, one channel per item. A pass adds nine rows, or eight rows
// and the running sum held for the channel, in a fixed tree of round-to-nearest-even adds; a pass
// with tlast scales the sum, clamps it and returns one item, otherwise the sum is written back to
// a MAX_CHANNELS x 32 sum memory (entries are undefined until first written; there is no clearing
// pass). One item is taken per cycle unless the input is held or the output stalls. The sum is
// written back at the end of the four-stage adder pipeline, so a pass that reads the stored sum
// is held at the input while an unfinished pass to the same entry is in any of those stages,
// and longer while a stalled result holds the pipeline.
module multipass_average_pool_f32 import mapool_pkg::*; #(
   parameter int MAX_CHANNELS = 1024
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   // channel[9:0], row_0 .. row_8 (32 bits each) from bit 10 up, zero pad to 304 bits
   input  wire logic [303:0] req_tdata,
   // first_pass
   input  wire logic req_tuser,
   input  wire logic req_tlast,
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   // average[31:0], out_channel[41:32], zero pad to 48 bits
   output logic [47:0] rsp_tdata,
   input  wire logic csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [FP_W-1:0] csr_wdata
);

   cfg_type cfg_ff;
   logic [ROWS-1:0][FP_W-1:0] rows;
   logic sum_valid, sum_ready;
   sum_item_type sum_item;
   logic [FP_W-1:0] average;
   logic [CHAN_W-1:0] out_channel;

   always_comb begin
      for (int i = 0; i < ROWS; i++) begin
         rows[i] = req_tdata[CHAN_W + FP_W * i +: FP_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale <= SCALE_RESET;
         cfg_ff.clamp_low <= CLAMP_LOW_RESET;
         cfg_ff.clamp_high <= CLAMP_HIGH_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_SCALE: begin
               cfg_ff.scale <= csr_wdata;
            end
            CSR_CLAMP_LOW: begin
               cfg_ff.clamp_low <= csr_wdata;
            end
            CSR_CLAMP_HIGH: begin
               cfg_ff.clamp_high <= csr_wdata;
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   mapool_sum #(
      .MAX_CHANNELS(MAX_CHANNELS)
   ) u_sum (
      .clock(clock),
      .reset(reset),
      .in_valid(req_tvalid),
      .in_ready(req_tready),
      .in_channel(req_tdata[CHAN_W-1:0]),
      .in_rows(rows),
      .in_first(req_tuser),
      .in_last(req_tlast),
      .out_valid(sum_valid),
      .out_ready(sum_ready),
      .out_item(sum_item)
   );

   mapool_scale u_scale (
      .clock(clock),
      .reset(reset),
      .in_valid(sum_valid),
      .in_ready(sum_ready),
      .in_item(sum_item),
      .cfg(cfg_ff),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_average(average),
      .out_channel(out_channel)
   );

   assign rsp_tdata = {6'd0, out_channel, average};

endmodule
`default_nettype wire

// File: design/mapool_checker.sv
`default_nettype none
module mapool_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tready,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [47:0] rsp_tdata
);

   // Results leave only through the output register, which reset empties.
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid ##1 !rsp_tvalid)
      else $error("result shown too soon after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("input not ready with an empty pipeline");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[47:42] == 6'd0)
      else $error("result padding not zero");

endmodule

bind multipass_average_pool_f32 mapool_checker u_mapool_checker (
   .clock(clock),
   .reset(reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);
`default_nettype wire
